### src/amr_beu_pkg.sv
// Shared types, constants and frame size tables for the AMR bandwidth-efficient unpacker.
// No dependencies; imported by amr_beu_back and the top level.
package amr_beu_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int RESULT_CAP     = 24;
    localparam int IN_Q_DEPTH     = 2;
    localparam int OUT_Q_DEPTH    = 4;

    typedef enum logic [1:0] {
        PH_MODE,
        PH_TOC,
        PH_SPEECH,
        PH_DROP
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_FT,
        ST_TRUNC,
        ST_TOO_MANY
    } t_status;

    typedef enum logic [2:0] {
        S_WORK,
        S_LAUNCH,
        S_HDR,
        S_END,
        S_FLUSH
    } t_seq_state;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] frame_index;
        logic       is_header;
        logic       frame_done;
        logic       packet_done;
        t_status    status;
    } t_result;

    // Speech bits per frame type, narrowband and wideband.
    localparam logic [8:0] NB_BITS [16] = '{
        9'd95, 9'd103, 9'd118, 9'd134, 9'd148, 9'd159, 9'd204, 9'd244,
        9'd40, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
    };
    localparam logic [8:0] WB_BITS [16] = '{
        9'd132, 9'd177, 9'd253, 9'd285, 9'd317, 9'd365, 9'd397, 9'd461,
        9'd477, 9'd40, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
    };
    localparam logic [15:0] NB_VALID = 16'h81FF;
    localparam logic [15:0] WB_VALID = 16'h83FF;

    function automatic logic [8:0] frame_bits(input logic band, input logic [3:0] ft);
        return band ? WB_BITS[ft] : NB_BITS[ft];
    endfunction

    function automatic logic ft_valid(input logic band, input logic [3:0] ft);
        return band ? WB_VALID[ft] : NB_VALID[ft];
    endfunction

endpackage

### src/amr_bandwidth_efficient_unpacker_core.sv
// Top level of the AMR bandwidth-efficient payload unpacker: queues, back end, config register.
// Depends on amr_beu_pkg, amr_beu_fifo and amr_beu_back.
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -------------------------------------------
//  item      in         push / full               i_in_byte, i_last_byte
//  result    out        pop / empty               o_out_byte, o_frame_index, o_is_header,
//                                                 o_frame_done, o_packet_done, o_status
//  config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata (band_select)
//
// An item enters the bit buffer; the sequencer then takes each table-of-contents entry and
// each speech byte in turn, and each frame header as a header store read, then the header
// byte; once the last frame of a payload is out, a further step finds no frame left.
// The final byte of a payload adds an end check and a flush to close the payload. The back
// end sequencer does one action per cycle, and holds while the result queue is full.
// Reset is synchronous, active low; the header store has no reset and is read only where
// written. Items wait in a 2-entry front queue and results in a 4-entry result queue,
// so either side may stall without blocking the other until its queue fills.
module amr_bandwidth_efficient_unpacker_core #(
    parameter int MAX_FRAMES = amr_beu_pkg::MAX_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [3:0]  o_frame_index,
    output logic        o_is_header,
    output logic        o_frame_done,
    output logic        o_packet_done,
    output logic [1:0]  o_status,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import amr_beu_pkg::*;

    // word index of band_select
    localparam logic REG_BAND_SELECT = 1'b0;

    logic                  r_band_select;
    logic                  cfg_wr;
    logic [$bits(t_item)-1:0]   w_in_data;
    logic                  w_in_empty;
    logic                  w_in_pop;
    t_item                 w_item;
    logic                  w_out_push;
    t_result               w_out_res;
    logic                  w_out_full;
    logic [$bits(t_result)-1:0] w_out_data;
    t_result               w_res;

    // Config: write on the access phase; pready is tied high so writes never wait.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BAND_SELECT) ? {31'b0, r_band_select} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_select <= 1'b0;
        end else if (cfg_wr && paddr[2] == REG_BAND_SELECT) begin
            r_band_select <= pwdata[0];
        end
    end

    // Front: take items into the front queue as long as it has room.
    amr_beu_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (IN_Q_DEPTH)
    ) u_front_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({i_in_byte, i_last_byte}),
        .o_full  (full),
        .i_pop   (w_in_pop),
        .o_data  (w_in_data),
        .o_empty (w_in_empty)
    );

    assign w_item = t_item'(w_in_data);

    // Back: parse the table of contents, sequence headers and speech bytes.
    amr_beu_back #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_band_select (r_band_select),
        .i_item_valid  (!w_in_empty),
        .i_item        (w_item),
        .o_item_pop    (w_in_pop),
        .o_res_push    (w_out_push),
        .o_res         (w_out_res),
        .i_res_full    (w_out_full)
    );

    // Result queue decouples the sequencer from the consumer.
    amr_beu_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_Q_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_data),
        .o_empty (empty)
    );

    assign w_res         = t_result'(w_out_data);
    assign o_out_byte    = w_res.out_byte;
    assign o_frame_index = w_res.frame_index;
    assign o_is_header   = w_res.is_header;
    assign o_frame_done  = w_res.frame_done;
    assign o_packet_done = w_res.packet_done;
    assign o_status      = w_res.status;

    // The sequencer never pushes into a full result queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_out_push && w_out_full))
        else $error("result pushed while result queue full");

    // The sequencer never takes an item from an empty front queue.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_pop && w_in_empty))
        else $error("item taken from empty front queue");

    // Every error result closes its payload and is never a header byte.
    a_error_ends_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && w_res.status != ST_OK) |-> (o_packet_done && !o_is_header))
        else $error("error result without packet_done");

endmodule

### src/amr_beu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module amr_beu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/amr_beu_fifo.sv
// Small register-based queue used for the item front end and for the result queue.
// No dependencies.
module amr_beu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### src/amr_beu_back.sv
// Back end: bit buffer, TOC parser and frame sequencer of the AMR unpacker.
// Depends on amr_beu_pkg and amr_beu_ram (header store).
module amr_beu_back #(
    parameter int MAX_FRAMES = amr_beu_pkg::MAX_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_band_select,
    input  logic                  i_item_valid,
    input  amr_beu_pkg::t_item    i_item,
    output logic                  o_item_pop,
    output logic                  o_res_push,
    output amr_beu_pkg::t_result  o_res,
    input  logic                  i_res_full
);
    import amr_beu_pkg::*;

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RW = $clog2(RESULT_CAP + 1);

    t_seq_state     r_state, n_state;
    t_phase         r_phase, n_phase;
    logic [15:0]    r_buf, n_buf;
    logic [4:0]     r_cnt, n_cnt;
    logic [CW-1:0]  r_total, n_total;
    logic [CW-1:0]  r_cursor, n_cursor;
    logic [8:0]     r_bits_left, n_bits_left;
    logic           r_last, n_last;
    logic [RW-1:0]  r_res_n, n_res_n;
    logic           r_pend_v, n_pend_v;
    t_result        r_pend, n_pend;

    logic           ram_we;
    logic           ram_re;
    logic [4:0]     ram_rdata;
    logic [15:0]    win;
    logic [5:0]     entry;
    logic [3:0]     take_n;
    logic [7:0]     take_mask;
    logic [7:0]     speech_byte;
    logic [8:0]     hdr_bits;
    logic [4:0]     cnt_base;
    logic           capped;
    logic           out_room;
    logic           all_done;
    logic           emit;
    t_result        emit_res;
    logic           push_direct;
    logic           push_pend;
    logic           flush_push;

    amr_beu_ram #(
        .WIDTH (5),
        .DEPTH (MAX_FRAMES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_total[AW-1:0]),
        .i_wdata (entry[4:0]),
        .i_re    (ram_re),
        .i_raddr (r_cursor[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Unread bits sit at the low end of the buffer; align them to the top.
    assign win         = r_buf << (5'd16 - r_cnt);
    assign entry       = win[15:10];
    assign take_n      = (r_bits_left < 9'd8) ? r_bits_left[3:0] : 4'd8;
    assign take_mask   = 8'hFF << (4'd8 - take_n);
    assign speech_byte = win[15:8] & take_mask;
    assign hdr_bits    = frame_bits(i_band_select, ram_rdata[4:1]);
    assign capped      = (r_res_n == RW'(RESULT_CAP));
    assign out_room    = capped || !((!r_last || r_pend_v) && i_res_full);
    assign all_done    = (r_bits_left == '0) && (r_cursor >= r_total);
    assign cnt_base    = (r_phase == PH_SPEECH && all_done) ? 5'd0 : r_cnt;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_cursor    = r_cursor;
        n_bits_left = r_bits_left;
        n_last      = r_last;
        n_res_n     = r_res_n;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        o_item_pop  = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        emit        = 1'b0;
        emit_res    = '0;
        flush_push  = 1'b0;
        push_direct = 1'b0;
        push_pend   = 1'b0;

        unique case (r_state)
            S_WORK: begin
                if (r_phase == PH_TOC && r_cnt >= 5'd6) begin
                    if (!ft_valid(i_band_select, entry[4:1]) ||
                        r_total >= CW'(MAX_FRAMES)) begin
                        if (out_room) begin
                            emit                 = 1'b1;
                            emit_res.frame_index = 4'(r_cursor);
                            emit_res.packet_done = 1'b1;
                            emit_res.status      = ft_valid(i_band_select, entry[4:1]) ?
                                                   ST_TOO_MANY : ST_BAD_FT;
                            n_phase              = PH_DROP;
                            n_cnt                = '0;
                            n_buf                = '0;
                        end
                    end else begin
                        ram_we  = 1'b1;
                        n_total = r_total + CW'(1);
                        n_cnt   = r_cnt - 5'd6;
                        if (!entry[5]) begin
                            n_phase     = PH_SPEECH;
                            n_cursor    = '0;
                            n_bits_left = '0;
                            n_state     = S_LAUNCH;
                        end
                    end
                end else if (r_phase == PH_SPEECH && r_bits_left != '0 &&
                             r_cnt >= {1'b0, take_n}) begin
                    if (out_room) begin
                        emit                 = 1'b1;
                        emit_res.out_byte    = speech_byte;
                        emit_res.frame_index = 4'(r_cursor);
                        emit_res.frame_done  = (r_bits_left == 9'(take_n));
                        emit_res.status      = ST_OK;
                        n_cnt                = r_cnt - 5'(take_n);
                        n_bits_left          = r_bits_left - 9'(take_n);
                        if (r_bits_left == 9'(take_n)) begin
                            n_cursor = r_cursor + CW'(1);
                            n_state  = S_LAUNCH;
                        end
                    end
                end else if (r_last) begin
                    n_state = S_END;
                end else if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_res_n    = '0;
                    n_last     = i_item.last_byte;
                    if (r_phase != PH_DROP) begin
                        n_buf = {r_buf[7:0], i_item.in_byte};
                        if (r_phase == PH_MODE) begin
                            // skip the 4-bit mode request
                            n_cnt   = 5'd4;
                            n_phase = PH_TOC;
                        end else begin
                            n_cnt = cnt_base + 5'd8;
                        end
                    end
                end
            end
            S_LAUNCH: begin
                if (r_cursor < r_total) begin
                    ram_re  = 1'b1;
                    n_state = S_HDR;
                end else begin
                    n_state = S_WORK;
                end
            end
            S_HDR: begin
                if (out_room) begin
                    emit                 = 1'b1;
                    emit_res.out_byte    = {1'b0, ram_rdata, 2'b00};
                    emit_res.frame_index = 4'(r_cursor);
                    emit_res.is_header   = 1'b1;
                    emit_res.frame_done  = (hdr_bits == '0);
                    emit_res.status      = ST_OK;
                    if (hdr_bits == '0) begin
                        n_cursor = r_cursor + CW'(1);
                        n_state  = S_LAUNCH;
                    end else begin
                        n_bits_left = hdr_bits;
                        n_state     = S_WORK;
                    end
                end
            end
            S_END: begin
                if (r_phase == PH_DROP) begin
                    n_state = S_FLUSH;
                end else if (r_phase == PH_SPEECH && all_done) begin
                    n_pend_v = 1'b1;
                    if (r_pend_v) begin
                        n_pend.packet_done = 1'b1;
                    end else begin
                        n_pend             = '0;
                        n_pend.packet_done = 1'b1;
                    end
                    n_state = S_FLUSH;
                end else if (out_room) begin
                    emit                 = 1'b1;
                    emit_res.frame_index = 4'(r_cursor);
                    emit_res.packet_done = 1'b1;
                    emit_res.status      = ST_TRUNC;
                    n_state              = S_FLUSH;
                end
                if (n_state == S_FLUSH) begin
                    n_phase     = PH_MODE;
                    n_buf       = '0;
                    n_cnt       = '0;
                    n_total     = '0;
                    n_cursor    = '0;
                    n_bits_left = '0;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || !i_res_full) begin
                    flush_push = r_pend_v;
                    n_pend_v   = 1'b0;
                    n_last     = 1'b0;
                    n_state    = S_WORK;
                end
            end
            default: begin
                n_state = S_WORK;
            end
        endcase

        // Hold the newest result of a final item back so packet_done can be set on it.
        if (emit && !capped) begin
            n_res_n = r_res_n + RW'(1);
            if (!r_last) begin
                push_direct = 1'b1;
            end else begin
                push_pend = r_pend_v;
                n_pend_v  = 1'b1;
                n_pend    = emit_res;
            end
        end
    end

    assign o_res_push = push_direct || push_pend || flush_push;
    assign o_res      = push_direct ? emit_res : r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WORK;
            r_phase     <= PH_MODE;
            r_buf       <= '0;
            r_cnt       <= '0;
            r_total     <= '0;
            r_cursor    <= '0;
            r_bits_left <= '0;
            r_last      <= 1'b0;
            r_res_n     <= '0;
            r_pend_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_cursor    <= n_cursor;
            r_bits_left <= n_bits_left;
            r_last      <= n_last;
            r_res_n     <= n_res_n;
            r_pend_v    <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

### bench/testbench.sv
// Self-checking bench for amr_bandwidth_efficient_unpacker_core: payload bytes in, results out.
// Predicts every result with its own unpacker model and compares results field by field.
// Depends on amr_beu_pkg and the RTL of the unpacker core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import amr_beu_pkg::*;

    localparam int FRAME_LIMIT = MAX_FRAMES_DEF;
    localparam int RANDOM_ITEMS = 350;
    localparam logic [2:0] BAND_ADDR = 3'd0;   // band_select register, index 0

    // payload kinds for the random part
    localparam int PK_GOOD = 0;
    localparam int PK_BAD_TYPE = 1;
    localparam int PK_TOO_MANY = 2;
    localparam int PK_CUT = 3;
    localparam int PK_NOISE = 4;

    // frame type mixes
    localparam int FT_MIXED = 0;
    localparam int FT_LARGE = 1;
    localparam int FT_LEAN = 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_last_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic [3:0]  o_frame_index;
    logic        o_is_header;
    logic        o_frame_done;
    logic        o_packet_done;
    logic [1:0]  o_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    amr_bandwidth_efficient_unpacker_core #(.MAX_FRAMES(FRAME_LIMIT)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_in_byte(i_in_byte), .i_last_byte(i_last_byte),
        .empty(empty), .pop(pop), .o_out_byte(o_out_byte), .o_frame_index(o_frame_index),
        .o_is_header(o_is_header), .o_frame_done(o_frame_done),
        .o_packet_done(o_packet_done), .o_status(o_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // ------------------------------------------------------------------
    // Unpacker state as the bench sees it
    // ------------------------------------------------------------------
    t_phase      pl_phase;
    logic [15:0] bit_window;       // last 16 payload bits
    int unsigned bits_held;        // unread bits at the bottom of bit_window
    logic [4:0]  toc_entries [FRAME_LIMIT];
    int unsigned frames_listed;
    int unsigned frames_out;
    int unsigned speech_left;      // bits still owed by the open frame
    logic        band_sel;

    t_result     due_results [$];  // results predicted but not yet seen
    int unsigned step_added;       // results added by the byte being unpacked
    int unsigned useful_items;     // accepted bytes that the block did not drop
    int unsigned mismatches;

    // payload under construction
    bit          staged_bits [$];
    logic [7:0]  payload_bytes [$];

    // sender burst state and receiver hold request
    int unsigned burst_left;
    int unsigned stall_request;

    // Speech bits per frame type; zero marks both the empty frame and undefined types.
    function automatic int unsigned speech_bits(input logic wb, input logic [3:0] ft);
        case (ft)
            4'd0: return wb ? 132 : 95;
            4'd1: return wb ? 177 : 103;
            4'd2: return wb ? 253 : 118;
            4'd3: return wb ? 285 : 134;
            4'd4: return wb ? 317 : 148;
            4'd5: return wb ? 365 : 159;
            4'd6: return wb ? 397 : 204;
            4'd7: return wb ? 461 : 244;
            4'd8: return wb ? 477 : 40;
            4'd9: return wb ? 40 : 0;
            default: return 0;
        endcase
    endfunction

    function automatic void add_result(input logic [7:0] value, input int unsigned frame,
                                       input logic hdr, input logic fdone, input logic pdone,
                                       input t_status st);
        t_result r;
        if (step_added >= RESULT_CAP)
            return;
        r.out_byte = value;
        r.frame_index = frame[3:0];
        r.is_header = hdr;
        r.frame_done = fdone;
        r.packet_done = pdone;
        r.status = st;
        due_results.push_back(r);
        step_added++;
    endfunction

    function automatic void restart_payload();
        pl_phase = PH_MODE;
        bit_window = '0;
        bits_held = 0;
        frames_listed = 0;
        frames_out = 0;
        speech_left = 0;
    endfunction

    // Error result, then drop the rest of the payload.
    function automatic void abort_payload(input t_status st);
        add_result(8'h00, frames_out, 1'b0, 1'b0, 1'b1, st);
        pl_phase = PH_DROP;
        bits_held = 0;
        bit_window = '0;
    endfunction

    // Emit header bytes until a frame with speech is open or all frames are out.
    function automatic void open_frames();
        logic [4:0] h;
        int unsigned sz;
        while (speech_left == 0 && frames_out < frames_listed && frames_out < FRAME_LIMIT) begin
            h = toc_entries[frames_out];
            sz = speech_bits(band_sel, h[4:1]);
            if (sz == 0) begin
                add_result({1'b0, h, 2'b00}, frames_out, 1'b1, 1'b1, 1'b0, ST_OK);
                frames_out++;
            end else begin
                add_result({1'b0, h, 2'b00}, frames_out, 1'b1, 1'b0, 1'b0, ST_OK);
                speech_left = sz;
            end
        end
    endfunction

    // Advance the unpacker by one payload byte and queue the results it yields.
    function automatic void unpack_byte(input logic [7:0] b, input logic last);
        logic [5:0]  entry;
        int unsigned n;
        int unsigned chunk;
        step_added = 0;
        if (pl_phase != PH_DROP) begin
            useful_items++;
            bit_window = {bit_window[7:0], b};
            bits_held += 8;
        end
        if (pl_phase == PH_MODE && bits_held >= 4) begin
            bits_held -= 4;
            pl_phase = PH_TOC;
        end
        while (pl_phase == PH_TOC && bits_held >= 6) begin
            entry = 6'(bit_window >> (bits_held - 6));
            bits_held -= 6;
            if (entry[4:1] != 4'hF && speech_bits(band_sel, entry[4:1]) == 0) begin
                abort_payload(ST_BAD_FT);
            end else if (frames_listed >= FRAME_LIMIT) begin
                abort_payload(ST_TOO_MANY);
            end else begin
                toc_entries[frames_listed] = entry[4:0];
                frames_listed++;
                if (!entry[5]) begin
                    pl_phase = PH_SPEECH;
                    frames_out = 0;
                    speech_left = 0;
                    open_frames();
                end
            end
        end
        if (pl_phase == PH_SPEECH) begin
            while (speech_left > 0) begin
                n = speech_left < 8 ? speech_left : 8;
                if (bits_held < n)
                    break;
                chunk = (32'(bit_window) >> (bits_held - n)) & ((32'd1 << n) - 1);
                bits_held -= n;
                speech_left -= n;
                add_result(8'(chunk << (8 - n)), frames_out, 1'b0, speech_left == 0,
                           1'b0, ST_OK);
                if (speech_left == 0) begin
                    frames_out++;
                    open_frames();
                end
            end
            // all frames out: trailing bits are padding
            if (speech_left == 0 && frames_out >= frames_listed)
                bits_held = 0;
        end
        if (last) begin
            if (pl_phase == PH_DROP) begin
                // the error result already closed the payload
            end else if (pl_phase == PH_SPEECH && speech_left == 0 &&
                         frames_out >= frames_listed) begin
                if (step_added > 0)
                    due_results[due_results.size() - 1].packet_done = 1'b1;
                else
                    add_result(8'h00, 0, 1'b0, 1'b0, 1'b1, ST_OK);
            end else begin
                abort_payload(ST_TRUNC);
            end
            restart_payload();
        end
    endfunction

    // ------------------------------------------------------------------
    // Payload construction
    // ------------------------------------------------------------------
    function automatic void add_bits(input int unsigned value, input int width);
        for (int i = width - 1; i >= 0; i--)
            staged_bits.push_back(value[i]);
    endfunction

    function automatic logic [3:0] pick_ft(input logic wb, input int mix);
        int roll;
        roll = $urandom_range(0, 19);
        if (mix == FT_LARGE)
            return 4'($urandom_range(0, 7));
        if (roll < 8)
            return 4'hF;
        if (roll < 15 || mix == FT_LEAN)
            return wb ? 4'd9 : 4'd8;
        return 4'($urandom_range(0, wb ? 9 : 8));
    endfunction

    // Build one payload into payload_bytes for the current band.
    function automatic void make_payload(input int kind, input int mix);
        int         n_entries;
        int         bad_at;
        int         keep;
        int         roll;
        logic [3:0] ft;
        logic [3:0] fts [$];
        logic [7:0] b;
        staged_bits.delete();
        payload_bytes.delete();
        if (kind == PK_NOISE) begin
            repeat ($urandom_range(1, 8))
                payload_bytes.push_back(8'($urandom));
            return;
        end
        add_bits($urandom_range(0, 15), 4);
        roll = $urandom_range(0, 9);
        if (kind == PK_TOO_MANY)
            n_entries = FRAME_LIMIT + $urandom_range(1, 2);
        else if (roll == 0)
            n_entries = FRAME_LIMIT;
        else if (roll == 1)
            n_entries = $urandom_range(4, FRAME_LIMIT - 1);
        else
            n_entries = $urandom_range(1, 3);
        if (n_entries > 3 && mix == FT_MIXED)
            mix = FT_LEAN;
        bad_at = (kind == PK_BAD_TYPE) ? $urandom_range(0, n_entries - 1) : -1;
        for (int i = 0; i < n_entries; i++) begin
            if (i == bad_at) begin
                ft = 4'($urandom_range(band_sel ? 10 : 9, 14));
                add_bits(32'({1'($urandom_range(0, 1)), ft, 1'($urandom_range(0, 1))}), 6);
                break;
            end
            ft = pick_ft(band_sel, mix);
            fts.push_back(ft);
            add_bits(32'({(i != n_entries - 1 || kind == PK_TOO_MANY), ft,
                          1'($urandom_range(0, 1))}), 6);
        end
        if (kind == PK_GOOD || kind == PK_CUT) begin
            foreach (fts[i])
                repeat (speech_bits(band_sel, fts[i]))
                    staged_bits.push_back(1'($urandom_range(0, 1)));
        end else begin
            add_bits($urandom, $urandom_range(0, 16));
        end
        // pad with random bits; the block must ignore them
        while (staged_bits.size() % 8 != 0)
            staged_bits.push_back(1'($urandom_range(0, 1)));
        for (int i = 0; i < staged_bits.size(); i += 8) begin
            for (int k = 0; k < 8; k++)
                b[7 - k] = staged_bits[i + k];
            payload_bytes.push_back(b);
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                payload_bytes.push_back(8'($urandom));
        if (kind == PK_CUT && payload_bytes.size() > 1) begin
            keep = $urandom_range(1, payload_bytes.size() - 1);
            while (payload_bytes.size() > keep)
                void'(payload_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, time limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cover the slowest legal run several times over, hold-off and patterns included.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: the stall pattern and the checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
            mismatches++;
        end
    endfunction

    // Receiver: switch among steady, coin-flip and sparse popping; honor hold requests.
    initial begin
        int unsigned hold_left;
        int unsigned mode;
        int unsigned mode_left;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                hold_left = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && !empty && pop) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %0h frame %0d",
                         $realtime, o_out_byte, o_frame_index);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("frame_index", want.frame_index, o_frame_index);
                check_field("is_header", want.is_header, o_is_header);
                check_field("frame_done", want.frame_done, o_frame_done);
                check_field("packet_done", want.packet_done, o_packet_done);
                check_field("status", want.status, o_status);
            end
        end
    end

    // ------------------------------------------------------------------
    // Item side and configuration port
    // ------------------------------------------------------------------
    // Offer one byte in bursts with random gaps; predict once the block takes it.
    task automatic send_item(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        unpack_byte(b, last);
    endtask

    task automatic send_payload();
        foreach (payload_bytes[i])
            send_item(payload_bytes[i], i == payload_bytes.size() - 1);
    endtask

    // Hold the sender until every predicted result is in, then let the block settle.
    task automatic wait_results_drained(input int unsigned tail);
        @(negedge i_clk);
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_band(input logic value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BAND_ADDR;
        pwdata <= {31'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        band_sel = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_band_readback();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= BAND_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field("band_select readback", {31'b0, band_sel}, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_value();
        check_band_readback();
    endtask

    // Short hand-made payloads in narrowband, one per corner of the format.
    task automatic test_directed_cases();
        // one byte: table of contents cut off
        payload_bytes = '{8'h5A};
        send_payload();
        // all zeros: frame type 0 opens, then the payload ends mid-frame
        payload_bytes = '{8'h00, 8'h00, 8'h00};
        send_payload();
        // all ones: every entry continues, the seventeenth overflows the frame list
        payload_bytes.delete();
        repeat (14) payload_bytes.push_back(8'hFF);
        send_payload();
        // one zero-size frame, then a trailing byte that yields only the end marker
        payload_bytes = '{8'hA7, 8'hC0, 8'h00};
        send_payload();
        // frame type 9 is undefined in narrowband; drop the rest silently
        payload_bytes = '{8'h0C, 8'h80, 8'h33};
        send_payload();
    endtask

    // Hold the receiver for a long stretch while large frames keep coming.
    task automatic test_receiver_hold();
        wait_results_drained(32);
        write_band(1'b0);
        @(posedge i_clk);
        stall_request = 300;
        make_payload(PK_GOOD, FT_LARGE);
        send_payload();
    endtask

    // Let every result out before the next payload starts.
    task automatic test_sender_pause();
        make_payload(PK_GOOD, FT_MIXED);
        send_payload();
        wait_results_drained(0);
        make_payload(PK_GOOD, FT_MIXED);
        send_payload();
    endtask

    // Phases of random payloads, each under a band setting chosen while idle.
    task automatic test_random_payloads();
        int unsigned start_items;
        int unsigned phase_no;
        int          roll;
        int          kind;
        start_items = useful_items;
        phase_no = 0;
        while (useful_items - start_items < RANDOM_ITEMS) begin
            wait_results_drained(32);
            write_band(phase_no < 2 ? phase_no[0] : 1'($urandom_range(0, 1)));
            check_band_readback();
            phase_no++;
            repeat ($urandom_range(3, 6)) begin
                roll = $urandom_range(0, 19);
                if (roll < 13)
                    kind = PK_GOOD;
                else if (roll < 15)
                    kind = PK_BAD_TYPE;
                else if (roll < 16)
                    kind = PK_TOO_MANY;
                else if (roll < 19)
                    kind = PK_CUT;
                else
                    kind = PK_NOISE;
                make_payload(kind, FT_MIXED);
                send_payload();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_byte = 8'h00;
        i_last_byte = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = BAND_ADDR;
        pwdata = 32'h0;
        burst_left = 0;
        stall_request = 0;
        mismatches = 0;
        useful_items = 0;
        band_sel = 1'b0;
        restart_payload();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_value();
        test_directed_cases();
        test_receiver_hold();
        test_sender_pause();
        test_random_payloads();

        wait_results_drained(40);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
